FILE: sv/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg: shared types and constants for the polynomial coefficient evaluator
// Request codes, field widths and the step control word that the sequencer
// hands to the Horner datapath.
// ----------------------------------------------------------------------------
package pce_pkg;

    // field widths
    localparam int REQ_W  = 2;
    localparam int IDX_W  = 5;
    localparam int COEF_W = 32;
    localparam int ACC_W  = 48;

    // default table size (highest exponent)
    localparam int MAX_DEGREE_DEF = 31;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVAL  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    // one strobe for the start of evaluation and one per phase of a Horner step
    typedef struct packed {
        logic load;     // start of evaluation: clear acc, take |x|
        logic abs_en;   // take |acc| and product sign
        logic mul_lo;   // low partial product
        logic mul_hi;   // high partial product, round low part
        logic rnd;      // combine partial products, clamp
        logic acc;      // add coefficient, saturate
    } pce_step_ctl_t;

endpackage

FILE: sv/pce_horner.sv
// ----------------------------------------------------------------------------
// pce_horner: Horner step datapath
// One shared 32x32 unsigned multiplier forms |acc|*|x| in two partial products;
// the product is rounded half away from zero to Q32.16, signed, added to the
// coefficient and saturated to 48 bits. Five control phases per step.
// ----------------------------------------------------------------------------
module pce_horner (
    input  logic                                clk,
    input  pce_pkg::pce_step_ctl_t              ctl,
    input  logic signed [pce_pkg::COEF_W-1:0]   x_point,
    input  logic signed [pce_pkg::COEF_W-1:0]   coef,
    output logic signed [pce_pkg::ACC_W-1:0]    acc,
    output logic                                ovf
);
    import pce_pkg::*;

    localparam int SUM_W = ACC_W + 3;
    localparam int RND_W = ACC_W + 1;
    localparam int PRD_W = 2 * COEF_W;
    localparam logic [PRD_W:0] R_CAP = (PRD_W+1)'(1) << ACC_W;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((65'(1) << (ACC_W-1)) - 65'(1));
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    logic [COEF_W-1:0]        b_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     ovf_reg;
    logic [ACC_W-1:0]         mag_reg;
    logic                     sneg_reg;
    logic [PRD_W-1:0]         plo_reg;
    logic [ACC_W-1:0]         phi_reg;
    logic [RND_W-1:0]         lowr_reg;
    logic [RND_W-1:0]         r_reg;

    logic [COEF_W-1:0]        mul_a;
    logic [PRD_W-1:0]         mul_p;
    logic [RND_W-1:0]         lowr_next;
    logic [PRD_W:0]           rnd_full;
    logic [RND_W-1:0]         r_next;
    logic signed [SUM_W-1:0]  c_ext;
    logic signed [SUM_W-1:0]  r_ext;
    logic signed [SUM_W-1:0]  sum;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     sat_hit;

    // shared multiplier: low 32 bits of |acc|, then high 16 bits
    assign mul_a = ctl.mul_lo ? mag_reg[COEF_W-1:0]
                              : COEF_W'(mag_reg[ACC_W-1:COEF_W]);
    assign mul_p = PRD_W'(mul_a) * PRD_W'(b_reg);

    // rounding of the low partial product
    assign lowr_next = RND_W'((65'(plo_reg) + 65'h8000) >> 16);

    // combine, clamp magnitude to 2^48
    assign rnd_full = {1'b0, phi_reg, 16'b0} + (PRD_W+1)'(lowr_reg);
    assign r_next   = (rnd_full > R_CAP) ? R_CAP[RND_W-1:0] : rnd_full[RND_W-1:0];

    // signed add of coefficient and saturation
    assign c_ext = SUM_W'(coef);
    assign r_ext = signed'(SUM_W'(r_reg));
    assign sum   = sneg_reg ? (c_ext - r_ext) : (c_ext + r_ext);

    always_comb
    begin
        sat_hit  = 1'b0;
        acc_next = sum[ACC_W-1:0];
        if (sum > SAT_MAX)
        begin
            sat_hit  = 1'b1;
            acc_next = SAT_MAX[ACC_W-1:0];
        end
        else if (sum < SAT_MIN)
        begin
            sat_hit  = 1'b1;
            acc_next = SAT_MIN[ACC_W-1:0];
        end
    end

    // step registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            b_reg   <= x_point[COEF_W-1] ? (COEF_W'(0) - COEF_W'(x_point))
                                         : COEF_W'(x_point);
        end
        if (ctl.abs_en)
        begin
            mag_reg  <= acc_reg[ACC_W-1] ? (ACC_W'(0) - ACC_W'(acc_reg))
                                         : ACC_W'(acc_reg);
            sneg_reg <= acc_reg[ACC_W-1] ^ x_point[COEF_W-1];
        end
        if (ctl.mul_lo)
        begin
            plo_reg <= mul_p;
        end
        if (ctl.mul_hi)
        begin
            phi_reg  <= mul_p[ACC_W-1:0];
            lowr_reg <= lowr_next;
        end
        if (ctl.rnd)
        begin
            r_reg <= r_next;
        end
        if (ctl.acc)
        begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_reg | sat_hit;
        end
    end

    assign acc = acc_reg;
    assign ovf = ovf_reg;

endmodule

FILE: sv/polynomial_coefficient_evaluator.sv
// ----------------------------------------------------------------------------
// polynomial_coefficient_evaluator: coefficient table with Horner evaluation
// Holds signed Q16.16 coefficients and serves write, saturating add, clear
// and evaluate requests; each request returns one result word.
// ----------------------------------------------------------------------------
//  channel   signals                                          handshake
//  request   req_type exponent_index coef_value x_point       start & !busy
//  result    poly_value degree_now all_zero overflow_flag     done (1 cycle)
//
//  Write, add and clear pass through the EXEC and FIN states from accept to done.
//  Evaluate runs one Horner step per table entry, D = min(MAX_DEGREE,31)+1 entries: each
//  Horner step runs five phases on the one shared 32x32 multiplier datapath.
//  busy is high from accept until done; a new word may start in the done cycle.
//  Reset clears all coefficients at once through per-entry nonzero bits.
//  done is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module polynomial_coefficient_evaluator #(
    parameter int MAX_DEGREE = pce_pkg::MAX_DEGREE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pce_pkg::REQ_W-1:0]           req_type,
    input  logic [pce_pkg::IDX_W-1:0]           exponent_index,
    input  logic signed [pce_pkg::COEF_W-1:0]   coef_value,
    input  logic signed [pce_pkg::COEF_W-1:0]   x_point,
    output logic                                done,
    output logic signed [pce_pkg::ACC_W-1:0]    poly_value,
    output logic [pce_pkg::IDX_W-1:0]           degree_now,
    output logic                                all_zero,
    output logic                                overflow_flag
);
    import pce_pkg::*;

    // only exponents reachable by a 5-bit index are stored
    localparam int TBL_DEPTH = (MAX_DEGREE < 32) ? (MAX_DEGREE + 1) : 32;
    localparam int PTR_W     = $clog2(TBL_DEPTH);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(TBL_DEPTH - 1);
    localparam logic signed [COEF_W:0] C_MAX = (COEF_W+1)'((33'(1) << (COEF_W-1)) - 33'(1));
    localparam logic signed [COEF_W:0] C_MIN = -C_MAX - (COEF_W+1)'(1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_ABS  = 3'd2;
    localparam logic [2:0] ST_MLO  = 3'd3;
    localparam logic [2:0] ST_MHI  = 3'd4;
    localparam logic [2:0] ST_RND  = 3'd5;
    localparam logic [2:0] ST_ACC  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [PTR_W-1:0]         ptr_reg;
    logic [TBL_DEPTH-1:0]     nz_reg;
    logic                     done_reg;
    logic [REQ_W-1:0]         type_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [COEF_W-1:0] x_reg;
    logic                     add_ovf_reg;
    logic signed [ACC_W-1:0]  poly_value_reg;
    logic [IDX_W-1:0]         degree_reg;
    logic                     all_zero_reg;
    logic                     ovf_out_reg;
    logic signed [COEF_W-1:0] rd_data_reg;

    logic signed [COEF_W-1:0] tbl_mem [TBL_DEPTH];

    logic                     idx_ok;
    logic [PTR_W-1:0]         rd_addr;
    logic [PTR_W-1:0]         cur_addr;
    logic signed [COEF_W-1:0] rd_data;
    logic signed [COEF_W:0]   add_sum;
    logic signed [COEF_W-1:0] add_val;
    logic                     add_sat;
    logic signed [COEF_W-1:0] wr_data;
    logic                     wr_en;
    logic [IDX_W-1:0]         deg_calc;
    pce_step_ctl_t            step_ctl;
    logic signed [ACC_W-1:0]  dp_acc;
    logic                     dp_ovf;

    assign busy = (state_reg != ST_IDLE);

    // table access: read port is registered, so the address goes out in the
    // cycle before the read (request index while idle, Horner pointer otherwise)
    assign idx_ok   = ({{(32-IDX_W){1'b0}}, idx_reg} < 32'(TBL_DEPTH));
    assign rd_addr  = (state_reg == ST_IDLE) ? exponent_index[PTR_W-1:0] : ptr_reg;
    assign cur_addr = (state_reg == ST_EXEC) ? idx_reg[PTR_W-1:0] : ptr_reg;
    assign rd_data  = nz_reg[cur_addr] ? rd_data_reg : '0;

    // saturating coefficient add
    assign add_sum = (COEF_W+1)'(rd_data) + (COEF_W+1)'(coef_reg);

    always_comb
    begin
        add_sat = 1'b0;
        add_val = add_sum[COEF_W-1:0];
        if (add_sum > C_MAX)
        begin
            add_sat = 1'b1;
            add_val = C_MAX[COEF_W-1:0];
        end
        else if (add_sum < C_MIN)
        begin
            add_sat = 1'b1;
            add_val = C_MIN[COEF_W-1:0];
        end
    end

    assign wr_data = (type_reg == REQ_ADD) ? add_val : coef_reg;
    assign wr_en   = (state_reg == ST_EXEC) && idx_ok &&
                     ((type_reg == REQ_WRITE) || (type_reg == REQ_ADD));

    // highest nonzero exponent
    always_comb
    begin
        deg_calc = '0;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            if (nz_reg[i])
            begin
                deg_calc = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_EXEC;
            ST_EXEC: state_next = (type_reg == REQ_EVAL) ? ST_ABS : ST_FIN;
            ST_ABS:  state_next = ST_MLO;
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_RND;
            ST_RND:  state_next = ST_ACC;
            ST_ACC:  state_next = (ptr_reg == '0) ? ST_FIN : ST_ABS;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath phase strobes
    always_comb
    begin
        step_ctl        = '0;
        step_ctl.load   = (state_reg == ST_EXEC) && (type_reg == REQ_EVAL);
        step_ctl.abs_en = (state_reg == ST_ABS);
        step_ctl.mul_lo = (state_reg == ST_MLO);
        step_ctl.mul_hi = (state_reg == ST_MHI);
        step_ctl.rnd    = (state_reg == ST_RND);
        step_ctl.acc    = (state_reg == ST_ACC);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            nz_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FIN);
            if (state_reg == ST_EXEC)
            begin
                ptr_reg <= PTR_TOP;
            end
            else if (state_reg == ST_ACC)
            begin
                ptr_reg <= ptr_reg - PTR_W'(1);
            end
            if (wr_en)
            begin
                nz_reg[idx_reg[PTR_W-1:0]] <= (wr_data != '0);
            end
            else if ((state_reg == ST_EXEC) && (type_reg == REQ_CLEAR))
            begin
                nz_reg <= '0;
            end
        end
    end

    // coefficient storage, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[idx_reg[PTR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    // request word and result word registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            type_reg <= req_type;
            idx_reg  <= exponent_index;
            coef_reg <= coef_value;
            x_reg    <= x_point;
        end
        if (state_reg == ST_EXEC)
        begin
            add_ovf_reg <= (type_reg == REQ_ADD) && idx_ok && add_sat;
        end
        if (state_reg == ST_FIN)
        begin
            poly_value_reg <= (type_reg == REQ_EVAL) ? dp_acc : '0;
            degree_reg     <= deg_calc;
            all_zero_reg   <= ~|nz_reg;
            case (type_reg)
                REQ_EVAL: ovf_out_reg <= dp_ovf;
                REQ_ADD:  ovf_out_reg <= add_ovf_reg;
                default:  ovf_out_reg <= 1'b0;
            endcase
        end
    end

    pce_horner u_horner (
        .clk     (clk),
        .ctl     (step_ctl),
        .x_point (x_reg),
        .coef    (rd_data),
        .acc     (dp_acc),
        .ovf     (dp_ovf)
    );

    assign done          = done_reg;
    assign poly_value    = poly_value_reg;
    assign degree_now    = degree_reg;
    assign all_zero      = all_zero_reg;
    assign overflow_flag = ovf_out_reg;

endmodule

FILE: sv/pce_checker.sv
// ----------------------------------------------------------------------------
// pce_checker: port-level checks for the polynomial coefficient evaluator
// Watches the request and result handshakes of the top level; bound below.
// ----------------------------------------------------------------------------
module pce_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [pce_pkg::REQ_W-1:0]           req_type,
    input  logic                                done,
    input  logic signed [pce_pkg::ACC_W-1:0]    poly_value,
    input  logic [pce_pkg::IDX_W-1:0]           degree_now,
    input  logic                                all_zero
);
    import pce_pkg::*;

    // result word only appears once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted word always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // done is a strobe and is never held high
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // clear reports an empty table in the done strobe that follows its EXEC and FIN states
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_CLEAR)) |=> ##2
            (done && all_zero && (degree_now == '0) && (poly_value == '0)))
        else $error("clear did not report an empty table");

endmodule

bind polynomial_coefficient_evaluator pce_checker u_pce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .done       (done),
    .poly_value (poly_value),
    .degree_now (degree_now),
    .all_zero   (all_zero)
);

FILE: verif/tb_polynomial_coefficient_evaluator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polynomial_coefficient_evaluator: self-checking bench for the evaluator
// A clocked driver issues request words from a queue that the stimulus block
// fills: a directed set of corner cases, then mostly well-formed programs
// (clear, writes, adds, evaluations) mixed with fully random words. A shadow
// coefficient table predicts every result word, and the monitor checks each
// done strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_polynomial_coefficient_evaluator;

    import pce_pkg::*;

    localparam int     TBL_TOP      = MAX_DEGREE_DEF;
    localparam int     RAND_WORDS   = 1950;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 170;
    localparam int     MAX_REPORTS  = 10;
    localparam longint ACC_HI       = 64'sd140737488355327;
    localparam longint ACC_LO       = -ACC_HI - 64'sd1;
    localparam longint COEF_HI      = 64'sd2147483647;
    localparam longint COEF_LO      = -COEF_HI - 64'sd1;

    typedef struct packed {
        logic [REQ_W-1:0]         kind;
        logic [IDX_W-1:0]         idx;
        logic signed [COEF_W-1:0] coef;
        logic signed [COEF_W-1:0] x;
        logic [6:0]               idle_pct;
    } request_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [IDX_W-1:0]        degree;
        logic                    zero;
        logic                    ovf;
    } result_t;

    // DUT ports
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [REQ_W-1:0]         req_type = '0;
    logic [IDX_W-1:0]         exponent_index = '0;
    logic signed [COEF_W-1:0] coef_value = '0;
    logic signed [COEF_W-1:0] x_point = '0;
    logic                     done;
    logic signed [ACC_W-1:0]  poly_value;
    logic [IDX_W-1:0]         degree_now;
    logic                     all_zero;
    logic                     overflow_flag;

    // bench state
    request_t                 request_queue[$];
    result_t                  pending_results[$];
    request_t                 cur_item = '0;
    logic signed [COEF_W-1:0] coef_shadow [0:TBL_TOP];
    logic [6:0]               idle_now = '0;
    int                       gap_cnt = 0;
    int                       err_cnt = 0;
    int                       stall_cnt = 0;
    int                       n_write = 0;
    int                       n_add = 0;
    int                       n_eval = 0;
    int                       n_clear = 0;
    int                       n_eval_sat = 0;
    int                       n_add_sat = 0;

    polynomial_coefficient_evaluator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .exponent_index (exponent_index),
        .coef_value     (coef_value),
        .x_point        (x_point),
        .done           (done),
        .poly_value     (poly_value),
        .degree_now     (degree_now),
        .all_zero       (all_zero),
        .overflow_flag  (overflow_flag)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i <= TBL_TOP; i++)
        begin
            coef_shadow[i] = '0;
        end
    end

    // Horner evaluation over the shadow table, Q32.16 accumulator with
    // magnitude rounding (half away from zero) and 48-bit saturation
    function automatic result_t eval_point(logic signed [COEF_W-1:0] x);
        result_t      r;
        longint       acc;
        longint       xl;
        longint       sum;
        logic [63:0]  a_mag;
        logic [63:0]  b_mag;
        logic [127:0] prod;
        bit           neg;
        int           i;
        r   = '0;
        acc = 0;
        xl  = x;
        for (i = TBL_TOP; i >= 0; i--)
        begin
            neg   = (acc < 0) != (xl < 0);
            a_mag = (acc < 0) ? -acc : acc;
            b_mag = (xl < 0) ? -xl : xl;
            prod  = ({64'd0, a_mag} * {64'd0, b_mag} + 128'h8000) >> 16;
            if (prod > (128'd1 << 48))
                prod = 128'd1 << 48;
            sum = neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
            sum = sum + longint'(coef_shadow[i]);
            if (sum > ACC_HI)
            begin
                sum   = ACC_HI;
                r.ovf = 1'b1;
            end
            else if (sum < ACC_LO)
            begin
                sum   = ACC_LO;
                r.ovf = 1'b1;
            end
            acc = sum;
        end
        r.value = acc[ACC_W-1:0];
        return r;
    endfunction

    // apply one request word to the shadow table and form its result word
    function automatic result_t apply_request(request_t rq);
        result_t r;
        longint  s;
        int      i;
        r = '0;
        case (rq.kind)
            REQ_WRITE:
            begin
                if (int'(rq.idx) <= TBL_TOP)
                    coef_shadow[rq.idx] = rq.coef;
            end
            REQ_ADD:
            begin
                if (int'(rq.idx) <= TBL_TOP)
                begin
                    s = longint'(coef_shadow[rq.idx]) + longint'(rq.coef);
                    if (s > COEF_HI)
                    begin
                        s     = COEF_HI;
                        r.ovf = 1'b1;
                    end
                    else if (s < COEF_LO)
                    begin
                        s     = COEF_LO;
                        r.ovf = 1'b1;
                    end
                    coef_shadow[rq.idx] = s[COEF_W-1:0];
                end
            end
            REQ_EVAL:
            begin
                r = eval_point(rq.x);
            end
            REQ_CLEAR:
            begin
                for (i = 0; i <= TBL_TOP; i++)
                    coef_shadow[i] = '0;
            end
            default: ;
        endcase
        // degree and zero flag after the update
        r.zero   = 1'b1;
        r.degree = '0;
        for (i = 0; i <= TBL_TOP; i++)
        begin
            if (coef_shadow[i] != 0)
            begin
                r.degree = IDX_W'(i);
                r.zero   = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic request_t mk(logic [REQ_W-1:0] k, logic [IDX_W-1:0] i,
                                    logic [COEF_W-1:0] c, logic [COEF_W-1:0] x);
        request_t rq;
        rq.kind     = k;
        rq.idx      = i;
        rq.coef     = c;
        rq.x        = x;
        rq.idle_pct = idle_now;
        return rq;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'h0;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_x();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'h0;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_0000;
            4: return $urandom_range(1) ? 32'h0000_8000 : 32'hFFFF_8000;
            5: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // driver: one request word per accept, optional sender gaps afterwards
    always @(posedge clk)
    begin
        request_t nxt;
        result_t  res;
        bit       taken;
        if (!rst_n)
        begin
            start   <= 1'b0;
            gap_cnt = 0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                res = apply_request(cur_item);
                pending_results.push_back(res);
                case (cur_item.kind)
                    REQ_WRITE: n_write++;
                    REQ_ADD:
                    begin
                        n_add++;
                        if (res.ovf)
                            n_add_sat++;
                    end
                    REQ_EVAL:
                    begin
                        n_eval++;
                        if (res.ovf)
                            n_eval_sat++;
                    end
                    default: n_clear++;
                endcase
                if ($urandom_range(99) < cur_item.idle_pct)
                    gap_cnt = ($urandom_range(7) == 0) ? $urandom_range(1, 170)
                                                       : $urandom_range(1, 3);
            end
            if (!start || taken)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                    start <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    nxt = request_queue.pop_front();
                    cur_item       <= nxt;
                    req_type       <= nxt.kind;
                    exponent_index <= nxt.idx;
                    coef_value     <= nxt.coef;
                    x_point        <= nxt.x;
                    start          <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every done strobe must match the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: result word with nothing pending", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (poly_value !== want.value || degree_now !== want.degree ||
                    all_zero !== want.zero || overflow_flag !== want.ovf)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: mismatch value exp %0d got %0d, degree exp %0d got %0d, %s",
                                 $realtime, want.value, poly_value, want.degree, degree_now,
                                 $sformatf("zero exp %0b got %0b, ovf exp %0b got %0b",
                                           want.zero, all_zero, want.ovf, overflow_flag));
                end
            end
        end
    end

    // watchdog on cycles with neither an accept nor a result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int  n_dir;
        int  k;
        int  phase;
        bit  wide;
        idle_now = '0;

        // directed corners
        request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom), $urandom, 32'h0));
        request_queue.push_back(mk(REQ_WRITE, 5'd0, 32'h7FFF_FFFF, $urandom));
        request_queue.push_back(mk(REQ_WRITE, 5'd31, 32'h8000_0000, $urandom));
        request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom), $urandom, 32'h7FFF_FFFF));
        request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom), $urandom, 32'h8000_0000));
        request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom), $urandom, 32'h0));
        request_queue.push_back(mk(REQ_ADD, 5'd31, 32'hFFFF_FFFF, $urandom));
        request_queue.push_back(mk(REQ_ADD, 5'd0, 32'h0000_0001, $urandom));
        request_queue.push_back(mk(REQ_CLEAR, IDX_W'($urandom), $urandom, $urandom));
        // rounding on exact halves, both signs
        request_queue.push_back(mk(REQ_WRITE, 5'd1, 32'h0000_0001, $urandom));
        request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom), $urandom, 32'h0000_8000));
        request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom), $urandom, 32'hFFFF_8000));
        request_queue.push_back(mk(REQ_WRITE, 5'd0, 32'h0001_0000, $urandom));
        request_queue.push_back(mk(REQ_ADD, 5'd5, 32'h0, $urandom));
        request_queue.push_back(mk(REQ_WRITE, 5'd1, 32'h0, $urandom));
        request_queue.push_back(mk(REQ_WRITE, 5'd0, 32'h0, $urandom));
        // add to empty entry, then add that saturates low
        request_queue.push_back(mk(REQ_ADD, 5'd3, 32'h8000_0000, $urandom));
        request_queue.push_back(mk(REQ_ADD, 5'd3, 32'h8000_0000, $urandom));
        request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom), $urandom, 32'h0001_0000));
        request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom), $urandom, 32'hFFFF_0000));
        request_queue.push_back(mk(REQ_CLEAR, IDX_W'($urandom), $urandom, $urandom));
        request_queue.push_back(mk(REQ_CLEAR, IDX_W'($urandom), $urandom, $urandom));
        request_queue.push_back(mk(REQ_WRITE, 5'd2, 32'h7FFF_FFFF, $urandom));
        request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom), $urandom, 32'h7FFF_FFFF));
        n_dir = request_queue.size();

        // random programs; four idle phases for the sender: 0, 55, 0, 36 percent
        while (request_queue.size() < n_dir + RAND_WORDS)
        begin
            k     = request_queue.size() - n_dir;
            phase = (k * 4) / RAND_WORDS;
            case (phase)
                1: idle_now = 7'd55;
                3: idle_now = 7'd36;
                default: idle_now = 7'd0;
            endcase
            if ($urandom_range(99) < 75)
            begin
                wide = ($urandom_range(3) == 0);
                if ($urandom_range(1))
                    request_queue.push_back(mk(REQ_CLEAR, IDX_W'($urandom),
                                               $urandom, $urandom));
                repeat ($urandom_range(1, 5))
                    request_queue.push_back(mk(REQ_WRITE,
                        wide ? IDX_W'($urandom) : IDX_W'($urandom_range(4)),
                        pick_coef(), $urandom));
                repeat ($urandom_range(0, 2))
                    request_queue.push_back(mk(REQ_ADD,
                        wide ? IDX_W'($urandom) : IDX_W'($urandom_range(4)),
                        pick_coef(), $urandom));
                repeat ($urandom_range(1, 3))
                    request_queue.push_back(mk(REQ_EVAL, IDX_W'($urandom),
                                               $urandom, pick_x()));
            end
            else
            begin
                request_queue.push_back(mk(REQ_W'($urandom), IDX_W'($urandom),
                                           $urandom, $urandom));
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || start || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            err_cnt++;
            $display("%0d result words never arrived", pending_results.size());
        end
        $display("covered %0d words: %0d writes, %0d adds, %0d evaluations, %0d clears",
                 n_write + n_add + n_eval + n_clear, n_write, n_add, n_eval, n_clear);
        $display("%0d evaluations and %0d adds saturated; %0d failures",
                 n_eval_sat, n_add_sat, err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
